>>> rtl/core/rsq_pkg.sv
// ----------------------------------------------------------------------------
// rsq_pkg
// Shared widths, latencies, status codes and the CORDIC arctangent table
// for the razor MR / R squared pipeline.
// ----------------------------------------------------------------------------
package rsq_pkg;

	localparam int MOMENTUM_WIDTH = 24;
	localparam int ANGLE_WIDTH    = 16;
	localparam int MW             = MOMENTUM_WIDTH;
	localparam int AW             = ANGLE_WIDTH;

	localparam int CFG_W   = 16;
	localparam int MET_W   = 23;
	localparam int OUT_W   = 24;
	localparam int STAT_W  = 2;
	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
	localparam logic [CFG_W-1:0] MIN_LEAD_PT_RST = 16'd26;

	// derived internal widths
	localparam int SQ2_W  = 2 * MW;
	localparam int ATBT_W = 2 * MW + 2;
	localparam int ZS_W   = MW + 5;
	localparam int SUMZ_W = 35;
	localparam int D_W    = 58;
	localparam int MTR_W  = 57;

	// square root unit
	localparam int SQ_ARG_W = 64;
	localparam int SQ_STEPS = 32;
	localparam int SQ_LAT   = SQ_STEPS;

	// CORDIC
	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_W     = 34;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

	// wide multiplier
	localparam int MUL_W   = 64;
	localparam int MUL_LAT = 2;

	// divider
	localparam int DIV_BITS = 24;
	localparam int DIV_LAT  = DIV_BITS + 1;

	// whole pipeline
	localparam int PIPE_DEPTH = 2 * SQ_LAT + 3;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_LOW_PT = 2'd1,
		ST_NCOMP  = 2'd2
	} status_t;

	typedef struct packed {
		logic        [SQ2_W-1:0]  at2;
		logic        [SQ2_W-1:0]  bt2;
		logic        [ATBT_W-1:0] atbt;
		logic signed [ZS_W-1:0]   zs;
		logic                     low_pt;
		logic        [MET_W-1:0]  met;
		logic signed [MW:0]       sx;
		logic signed [MW:0]       sy;
	} side_t;

	// atan(2^-i) in units of 2^-32 turns
	function automatic logic signed [CORDIC_W-1:0] atan_tab(input int i);
		logic signed [CORDIC_W-1:0] v;
		v = '0;
		case (i)
			0:  v = 34'sh020000000;
			1:  v = 34'sh012E4051D;
			2:  v = 34'sh009FB385B;
			3:  v = 34'sh0051111D4;
			4:  v = 34'sh0028B0D43;
			5:  v = 34'sh00145D7E1;
			6:  v = 34'sh000A2F61E;
			7:  v = 34'sh000517C55;
			8:  v = 34'sh00028BE53;
			9:  v = 34'sh000145F2E;
			10: v = 34'sh0000A2F98;
			11: v = 34'sh0000517CC;
			12: v = 34'sh000028BE6;
			13: v = 34'sh0000145F3;
			14: v = 34'sh00000A2F9;
			15: v = 34'sh00000517C;
			16: v = 34'sh0000028BE;
			17: v = 34'sh00000145F;
			18: v = 34'sh000000A2F;
			19: v = 34'sh000000517;
			20: v = 34'sh00000028B;
			21: v = 34'sh000000145;
			22: v = 34'sh0000000A2;
			23: v = 34'sh000000051;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/core/rsq_if.sv
// ----------------------------------------------------------------------------
// rsq_in_if / rsq_out_if
// Valid/ready channels carrying one event and one result transaction.
// ----------------------------------------------------------------------------
interface rsq_in_if;
	import rsq_pkg::*;
	logic                 valid;
	logic                 ready;
	logic signed [MW-1:0] hemi_a_px;
	logic signed [MW-1:0] hemi_a_py;
	logic signed [MW-1:0] hemi_a_pz;
	logic signed [MW-1:0] hemi_b_px;
	logic signed [MW-1:0] hemi_b_py;
	logic signed [MW-1:0] hemi_b_pz;
	logic [MET_W-1:0]     met_magnitude;
	logic [AW-1:0]        met_angle;

	modport source (output valid, hemi_a_px, hemi_a_py, hemi_a_pz, hemi_b_px, hemi_b_py,
		hemi_b_pz, met_magnitude, met_angle, input ready);
	modport sink (input valid, hemi_a_px, hemi_a_py, hemi_a_pz, hemi_b_px, hemi_b_py,
		hemi_b_pz, met_magnitude, met_angle, output ready);
endinterface

interface rsq_out_if;
	import rsq_pkg::*;
	logic              valid;
	logic              ready;
	logic [OUT_W-1:0]  mass_r;
	logic [OUT_W-1:0]  ratio_squared;
	logic [STAT_W-1:0] status;

	modport source (output valid, mass_r, ratio_squared, status, input ready);
	modport sink (input valid, mass_r, ratio_squared, status, output ready);
endinterface

>>> rtl/core/razor_mr_rsq_calc.sv
// ----------------------------------------------------------------------------
// razor_mr_rsq_calc
// Razor mass MR and R squared for two massless hemispheres and a polar
// missing transverse momentum.
//
// Usage:
//   evt  - input channel, one event per transaction (both hemisphere
//          momenta, missing pt magnitude and azimuth).
//   res  - output channel, one result per event: mass_r, ratio_squared
//          and status (0 valid, 1 leading pt too small, 2 not computable).
//   cfg_wr_en / cfg_wr_data - write of the leading pt threshold; change it
//          only while no event is in flight.
//   Two chained 32-stage square roots (hemisphere |p|, then MR) set the depth,
//   with the CORDIC, divider and wide products running alongside.
//   Throughput is one event per cycle while res is not stalled.
//   The pipeline advances as a whole whenever the output register is empty
//   or being taken; while res is stalled, evt.ready is low and nothing
//   moves, so no transaction is lost or repeated.
//   Reset clears all valid bits and restores the threshold to 26.
// ----------------------------------------------------------------------------
module razor_mr_rsq_calc (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [rsq_pkg::CFG_W-1:0]  cfg_wr_data,
	rsq_in_if.sink                     evt,
	rsq_out_if.source                  res
);
	import rsq_pkg::*;

	localparam int SIDE_N  = SQ_LAT + 2;
	localparam int MXY_N   = SQ_LAT + 1 - CORDIC_LAT;
	localparam int SMALL_N = SQ_LAT;
	localparam int NCOMP_N = SQ_LAT - 3;
	localparam int DIVD_N  = SQ_LAT - 2 - DIV_LAT;

	logic                   en;
	logic [CFG_W-1:0]       min_lead_pt_q;
	logic [PIPE_DEPTH-1:0]  vld_q;

	// stage 1
	logic signed [SQ2_W-1:0] axx, ayy, azz, bxx, byy, bzz;
	logic        [SQ2_W-1:0] at2_c, bt2_c, pa_c, pb_c;
	logic signed [MW:0]      sx_c, sy_c, sz_c;
	logic signed [2*MW+1:0]  sxx, syy;
	logic [2*CFG_W-1:0]      thr2;
	side_t                   side_c;
	side_t                   side_q [SIDE_N];
	logic [SQ_ARG_W-1:0]     pa_arg_s1, pb_arg_s1, pta_arg_s1, ptb_arg_s1;

	logic [SQ_STEPS-1:0]     pa_r, pb_r, pta_r, ptb_r, mr_r;
	logic signed [CORDIC_W-1:0] cos_v, sin_v;

	// missing momentum components
	logic signed [MET_W+CORDIC_W:0] mcx, mcy;
	logic signed [CORDIC_W-1:0] mx_q [MXY_N+1];
	logic signed [CORDIC_W-1:0] my_q [MXY_N+1];

	// stage 34
	side_t                   sd33, sd34;
	logic [SQ_STEPS:0]       sum_c, ptsum_c;
	logic signed [SUMZ_W-1:0] sm_c, sp_c;
	logic [2*SUMZ_W-3:0]     d_full;
	logic [D_W-1:0]          d_s34;
	logic [SQ_STEPS:0]       ptsum_s34;
	logic [SQ2_W-1:0]        ad_s34;
	logic                    zero_c;

	// stage 35 / 36 / 37
	logic [MET_W+SQ_STEPS:0] mpt_s35;
	logic signed [CORDIC_W+MW:0] mxsx_s35, mysy_s35;
	logic [D_W-1:0]          d_s35, d_s36;
	logic                    zero_s35, zero_s36;
	logic signed [MTR_W+4:0] mt_c;
	logic [MTR_W-1:0]        mtr2_s36;
	logic [2*MUL_W-1:0]      lhs_p, rhs_p;
	logic                    ncomp_s37;

	logic [DIV_BITS-1:0]     quo_v;
	logic                    sat_v;

	logic                    small_q [SMALL_N];
	logic                    ncomp_q [NCOMP_N];
	logic [DIV_BITS-1:0]     quo_q   [DIVD_N];
	logic                    sat_q   [DIVD_N];

	logic                    small_f, ncomp_f, sat_f;
	logic [DIV_BITS-1:0]     quo_f;

	assign en        = !vld_q[PIPE_DEPTH-1] || res.ready;
	assign evt.ready = en;
	assign res.valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_lead_pt_q <= MIN_LEAD_PT_RST;
		end else if (cfg_wr_en) begin
			min_lead_pt_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], evt.valid};
		end
	end

	// ---- stage 1: squares and sums
	assign axx  = evt.hemi_a_px * evt.hemi_a_px;
	assign ayy  = evt.hemi_a_py * evt.hemi_a_py;
	assign azz  = evt.hemi_a_pz * evt.hemi_a_pz;
	assign bxx  = evt.hemi_b_px * evt.hemi_b_px;
	assign byy  = evt.hemi_b_py * evt.hemi_b_py;
	assign bzz  = evt.hemi_b_pz * evt.hemi_b_pz;
	assign at2_c = $unsigned(axx) + $unsigned(ayy);
	assign bt2_c = $unsigned(bxx) + $unsigned(byy);
	assign pa_c  = at2_c + $unsigned(azz);
	assign pb_c  = bt2_c + $unsigned(bzz);
	assign sx_c  = {evt.hemi_a_px[MW-1], evt.hemi_a_px} + {evt.hemi_b_px[MW-1], evt.hemi_b_px};
	assign sy_c  = {evt.hemi_a_py[MW-1], evt.hemi_a_py} + {evt.hemi_b_py[MW-1], evt.hemi_b_py};
	assign sz_c  = {evt.hemi_a_pz[MW-1], evt.hemi_a_pz} + {evt.hemi_b_pz[MW-1], evt.hemi_b_pz};
	assign sxx   = sx_c * sx_c;
	assign syy   = sy_c * sy_c;
	assign thr2  = min_lead_pt_q * min_lead_pt_q;

	always_comb begin
		side_c.at2    = at2_c;
		side_c.bt2    = bt2_c;
		side_c.atbt   = $unsigned(sxx) + $unsigned(syy);
		side_c.zs     = {sz_c, 4'b0};
		side_c.low_pt = at2_c <= {{(SQ2_W-2*CFG_W){1'b0}}, thr2};
		side_c.met    = evt.met_magnitude;
		side_c.sx     = sx_c;
		side_c.sy     = sy_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_arg_s1  <= {{(SQ_ARG_W-SQ2_W-8){1'b0}}, pa_c, 8'b0};
			pb_arg_s1  <= {{(SQ_ARG_W-SQ2_W-8){1'b0}}, pb_c, 8'b0};
			pta_arg_s1 <= {{(SQ_ARG_W-SQ2_W-16){1'b0}}, at2_c, 16'b0};
			ptb_arg_s1 <= {{(SQ_ARG_W-SQ2_W-16){1'b0}}, bt2_c, 16'b0};
			side_q[0]  <= side_c;
			for (int i = 1; i < SIDE_N; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	rsq_isqrt u_sqrt_pa  (.clk(clk), .en(en), .arg(pa_arg_s1),  .root(pa_r));
	rsq_isqrt u_sqrt_pb  (.clk(clk), .en(en), .arg(pb_arg_s1),  .root(pb_r));
	rsq_isqrt u_sqrt_pta (.clk(clk), .en(en), .arg(pta_arg_s1), .root(pta_r));
	rsq_isqrt u_sqrt_ptb (.clk(clk), .en(en), .arg(ptb_arg_s1), .root(ptb_r));

	rsq_cordic u_cordic (
		.clk     (clk),
		.en      (en),
		.angle   (evt.met_angle),
		.cos_q30 (cos_v),
		.sin_q30 (sin_v)
	);

	// ---- missing momentum vector, stage 26 onward
	assign mcx = ($signed({1'b0, side_q[CORDIC_LAT-1].met}) * cos_v) >>> 22;
	assign mcy = ($signed({1'b0, side_q[CORDIC_LAT-1].met}) * sin_v) >>> 22;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_q[0] <= mcx[CORDIC_W-1:0];
			my_q[0] <= mcy[CORDIC_W-1:0];
			for (int i = 1; i <= MXY_N; i++) begin
				mx_q[i] <= mx_q[i-1];
				my_q[i] <= my_q[i-1];
			end
		end
	end

	// ---- stage 34: D, pt sum, |aT2 - bT2|
	assign sd33    = side_q[SIDE_N-2];
	assign sd34    = side_q[SIDE_N-1];
	assign sum_c   = {1'b0, pa_r} + {1'b0, pb_r};
	assign ptsum_c = {1'b0, pta_r} + {1'b0, ptb_r};
	assign sm_c    = $signed({1'b0, sum_c}) - {{(SUMZ_W-ZS_W){sd33.zs[ZS_W-1]}}, sd33.zs};
	assign sp_c    = $signed({1'b0, sum_c}) + {{(SUMZ_W-ZS_W){sd33.zs[ZS_W-1]}}, sd33.zs};
	assign d_full  = sm_c[SUMZ_W-2:0] * sp_c[SUMZ_W-2:0];

	always_ff @(posedge clk) begin
		if (en) begin
			d_s34     <= d_full[D_W-1:0];
			ptsum_s34 <= ptsum_c;
			ad_s34    <= (sd33.bt2 >= sd33.at2) ? sd33.bt2 - sd33.at2 : sd33.at2 - sd33.bt2;
		end
	end

	assign zero_c = (d_s34 == '0) || (sd34.atbt == '0);

	rsq_isqrt u_sqrt_mr (
		.clk  (clk),
		.en   (en),
		.arg  ({{(SQ_ARG_W-D_W+8){1'b0}}, d_s34[D_W-1:8]}),
		.root (mr_r)
	);

	rsq_mul64 u_mul_lhs (
		.clk (clk),
		.en  (en),
		.a   ({{(MUL_W-SQ2_W){1'b0}}, ad_s34}),
		.b   ({{(MUL_W-SQ2_W-8){1'b0}}, ad_s34, 8'b0}),
		.p   (lhs_p)
	);

	rsq_mul64 u_mul_rhs (
		.clk (clk),
		.en  (en),
		.a   ({{(MUL_W-ATBT_W){1'b0}}, sd34.atbt}),
		.b   ({{(MUL_W-D_W){1'b0}}, d_s34}),
		.p   (rhs_p)
	);

	// ---- stages 35 to 37: MTR squared and beta test
	assign mt_c = $signed({{(MTR_W+5-(MET_W+SQ_STEPS+1)){1'b0}}, mpt_s35})
		- {{(MTR_W+5-(CORDIC_W+MW+1)){mxsx_s35[CORDIC_W+MW]}}, mxsx_s35}
		- {{(MTR_W+5-(CORDIC_W+MW+1)){mysy_s35[CORDIC_W+MW]}}, mysy_s35};

	always_ff @(posedge clk) begin
		if (en) begin
			mpt_s35   <= sd34.met * ptsum_s34;
			mxsx_s35  <= mx_q[MXY_N] * sd34.sx;
			mysy_s35  <= my_q[MXY_N] * sd34.sy;
			d_s35     <= d_s34;
			zero_s35  <= zero_c;
			d_s36     <= d_s35;
			zero_s36  <= zero_s35;
			mtr2_s36  <= mt_c[MTR_W+4] ? '0 : mt_c[MTR_W:1];
			ncomp_s37 <= zero_s36 || (lhs_p >= rhs_p);
		end
	end

	rsq_div u_div (
		.clk (clk),
		.en  (en),
		.num (mtr2_s36),
		.den (d_s36),
		.quo (quo_v),
		.sat (sat_v)
	);

	// ---- flag alignment up to stage 66
	always_ff @(posedge clk) begin
		if (en) begin
			small_q[0] <= sd34.low_pt;
			for (int i = 1; i < SMALL_N; i++) begin
				small_q[i] <= small_q[i-1];
			end
			ncomp_q[0] <= ncomp_s37;
			for (int i = 1; i < NCOMP_N; i++) begin
				ncomp_q[i] <= ncomp_q[i-1];
			end
			quo_q[0] <= quo_v;
			sat_q[0] <= sat_v;
			for (int i = 1; i < DIVD_N; i++) begin
				quo_q[i] <= quo_q[i-1];
				sat_q[i] <= sat_q[i-1];
			end
		end
	end

	assign small_f = small_q[SMALL_N-1];
	assign ncomp_f = ncomp_q[NCOMP_N-1];
	assign sat_f   = sat_q[DIVD_N-1];
	assign quo_f   = quo_q[DIVD_N-1];

	// ---- output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (small_f) begin
				res.status        <= ST_LOW_PT;
				res.mass_r        <= '0;
				res.ratio_squared <= '0;
			end else if (ncomp_f) begin
				res.status        <= ST_NCOMP;
				res.mass_r        <= '0;
				res.ratio_squared <= '0;
			end else begin
				res.status        <= ST_OK;
				res.mass_r        <= (mr_r > {{(SQ_STEPS-OUT_W){1'b0}}, OUT_MAX})
					? OUT_MAX : mr_r[OUT_W-1:0];
				res.ratio_squared <= sat_f ? OUT_MAX : quo_f;
			end
		end
	end

endmodule

>>> rtl/core/rsq_isqrt.sv
// ----------------------------------------------------------------------------
// rsq_isqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module rsq_isqrt (
	input  logic                         clk,
	input  logic                         en,
	input  logic [rsq_pkg::SQ_ARG_W-1:0] arg,
	output logic [rsq_pkg::SQ_STEPS-1:0] root
);
	import rsq_pkg::*;

	logic [SQ_ARG_W-1:0] rem_in [SQ_STEPS];
	logic [SQ_ARG_W-1:0] rem_n  [SQ_STEPS];
	logic [SQ_ARG_W-1:0] rem_q  [SQ_STEPS];
	logic [SQ_ARG_W-1:0] trial  [SQ_STEPS];
	logic [SQ_STEPS-1:0] rt_in  [SQ_STEPS];
	logic [SQ_STEPS-1:0] rt_n   [SQ_STEPS];
	logic [SQ_STEPS-1:0] rt_q   [SQ_STEPS];

	always_comb begin
		rem_in[0] = arg;
		rt_in[0]  = '0;
		for (int k = 1; k < SQ_STEPS; k++) begin
			rem_in[k] = rem_q[k-1];
			rt_in[k]  = rt_q[k-1];
		end
		for (int k = 0; k < SQ_STEPS; k++) begin
			trial[k] = ({{(SQ_ARG_W-SQ_STEPS){1'b0}}, rt_in[k]} << (SQ_STEPS - k))
				| ({{(SQ_ARG_W-1){1'b0}}, 1'b1} << (2 * (SQ_STEPS - 1 - k)));
			if (rem_in[k] >= trial[k]) begin
				rem_n[k] = rem_in[k] - trial[k];
				rt_n[k]  = rt_in[k] | ({{(SQ_STEPS-1){1'b0}}, 1'b1} << (SQ_STEPS - 1 - k));
			end else begin
				rem_n[k] = rem_in[k];
				rt_n[k]  = rt_in[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQ_STEPS; k++) begin
				rem_q[k] <= rem_n[k];
				rt_q[k]  <= rt_n[k];
			end
		end
	end

	assign root = rt_q[SQ_STEPS-1];

endmodule

>>> rtl/core/rsq_cordic.sv
// ----------------------------------------------------------------------------
// rsq_cordic
// Pipelined rotation-mode CORDIC giving cos and sin in Q30, one
// micro-rotation per stage plus a quadrant fix-up stage.
// ----------------------------------------------------------------------------
module rsq_cordic (
	input  logic                                clk,
	input  logic                                en,
	input  logic [rsq_pkg::AW-1:0]              angle,
	output logic signed [rsq_pkg::CORDIC_W-1:0] cos_q30,
	output logic signed [rsq_pkg::CORDIC_W-1:0] sin_q30
);
	import rsq_pkg::*;

	logic signed [CORDIC_W-1:0] x_in [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] y_in [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] z_in [CORDIC_STEPS];
	logic        [1:0]          qd_in [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] x_n  [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] y_n  [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] z_n  [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] x_q  [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] y_q  [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] z_q  [CORDIC_STEPS];
	logic        [1:0]          qd_q [CORDIC_STEPS];
	logic signed [CORDIC_W-1:0] c_n, s_n, xl, yl;

	always_comb begin
		x_in[0]  = CORDIC_GAIN;
		y_in[0]  = '0;
		z_in[0]  = $signed({4'b0, angle[AW-3:0], {(32-AW){1'b0}}});
		qd_in[0] = angle[AW-1:AW-2];
		for (int k = 1; k < CORDIC_STEPS; k++) begin
			x_in[k]  = x_q[k-1];
			y_in[k]  = y_q[k-1];
			z_in[k]  = z_q[k-1];
			qd_in[k] = qd_q[k-1];
		end
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			if (!z_in[k][CORDIC_W-1]) begin
				x_n[k] = x_in[k] - (y_in[k] >>> k);
				y_n[k] = y_in[k] + (x_in[k] >>> k);
				z_n[k] = z_in[k] - atan_tab(k);
			end else begin
				x_n[k] = x_in[k] + (y_in[k] >>> k);
				y_n[k] = y_in[k] - (x_in[k] >>> k);
				z_n[k] = z_in[k] + atan_tab(k);
			end
		end
	end

	assign xl = x_q[CORDIC_STEPS-1];
	assign yl = y_q[CORDIC_STEPS-1];

	always_comb begin
		case (qd_q[CORDIC_STEPS-1])
			2'd0: begin
				c_n = xl;
				s_n = yl;
			end
			2'd1: begin
				c_n = -yl;
				s_n = xl;
			end
			2'd2: begin
				c_n = -xl;
				s_n = -yl;
			end
			default: begin
				c_n = yl;
				s_n = -xl;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < CORDIC_STEPS; k++) begin
				x_q[k]  <= x_n[k];
				y_q[k]  <= y_n[k];
				z_q[k]  <= z_n[k];
				qd_q[k] <= qd_in[k];
			end
			cos_q30 <= c_n;
			sin_q30 <= s_n;
		end
	end

endmodule

>>> rtl/core/rsq_mul64.sv
// ----------------------------------------------------------------------------
// rsq_mul64
// Two-stage 64 x 64 unsigned multiplier built from 32 x 32 partial products.
// ----------------------------------------------------------------------------
module rsq_mul64 (
	input  logic                        clk,
	input  logic                        en,
	input  logic [rsq_pkg::MUL_W-1:0]   a,
	input  logic [rsq_pkg::MUL_W-1:0]   b,
	output logic [2*rsq_pkg::MUL_W-1:0] p
);
	import rsq_pkg::*;

	localparam int HW = MUL_W / 2;

	logic [MUL_W-1:0] ll_s1, lh_s1, hl_s1, hh_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[HW-1:0]    * b[HW-1:0];
			lh_s1 <= a[HW-1:0]    * b[MUL_W-1:HW];
			hl_s1 <= a[MUL_W-1:HW] * b[HW-1:0];
			hh_s1 <= a[MUL_W-1:HW] * b[MUL_W-1:HW];
			p     <= {hh_s1, ll_s1}
				+ ({{HW{1'b0}}, lh_s1, {HW{1'b0}}})
				+ ({{HW{1'b0}}, hl_s1, {HW{1'b0}}});
		end
	end

endmodule

>>> rtl/core/rsq_div.sv
// ----------------------------------------------------------------------------
// rsq_div
// Pipelined restoring divider for R squared: floor(num * 2^16 / den),
// one quotient bit per stage, with a flag when the quotient overflows.
// ----------------------------------------------------------------------------
module rsq_div (
	input  logic                         clk,
	input  logic                         en,
	input  logic [rsq_pkg::MTR_W-1:0]    num,
	input  logic [rsq_pkg::D_W-1:0]      den,
	output logic [rsq_pkg::DIV_BITS-1:0] quo,
	output logic                         sat
);
	import rsq_pkg::*;

	localparam int RW = D_W + 1;

	logic [RW-1:0]       rem_q [DIV_BITS+1];
	logic [RW-1:0]       rem_n [DIV_BITS+1];
	logic [DIV_BITS-1:0] low_q [DIV_BITS+1];
	logic [DIV_BITS-1:0] low_n [DIV_BITS+1];
	logic [DIV_BITS-1:0] quo_q [DIV_BITS+1];
	logic [DIV_BITS-1:0] quo_n [DIV_BITS+1];
	logic [D_W-1:0]      den_q [DIV_BITS+1];
	logic                sat_q [DIV_BITS+1];
	logic [RW-1:0]       trial [DIV_BITS+1];

	always_comb begin
		rem_n[0] = {{(RW-MTR_W+8){1'b0}}, num[MTR_W-1:8]};
		low_n[0] = {num[7:0], {(DIV_BITS-8){1'b0}}};
		quo_n[0] = '0;
		trial[0] = '0;
		for (int k = 1; k <= DIV_BITS; k++) begin
			trial[k] = {rem_q[k-1][RW-2:0], low_q[k-1][DIV_BITS-1]};
			low_n[k] = {low_q[k-1][DIV_BITS-2:0], 1'b0};
			if (trial[k] >= {1'b0, den_q[k-1]}) begin
				rem_n[k] = trial[k] - {1'b0, den_q[k-1]};
				quo_n[k] = {quo_q[k-1][DIV_BITS-2:0], 1'b1};
			end else begin
				rem_n[k] = trial[k];
				quo_n[k] = {quo_q[k-1][DIV_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_q[0] <= den;
			sat_q[0] <= {{(D_W-MTR_W+8){1'b0}}, num[MTR_W-1:8]} >= den;
			for (int k = 0; k <= DIV_BITS; k++) begin
				rem_q[k] <= rem_n[k];
				low_q[k] <= low_n[k];
				quo_q[k] <= quo_n[k];
			end
			for (int k = 1; k <= DIV_BITS; k++) begin
				den_q[k] <= den_q[k-1];
				sat_q[k] <= sat_q[k-1];
			end
		end
	end

	assign quo = quo_q[DIV_BITS];
	assign sat = sat_q[DIV_BITS];

endmodule

>>> rtl/core/rsq_checker.sv
// ----------------------------------------------------------------------------
// rsq_checker
// Port-level checks of the razor MR / R squared block, bound to the top.
// ----------------------------------------------------------------------------
module rsq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [rsq_pkg::OUT_W-1:0]    mass_r,
	input logic [rsq_pkg::OUT_W-1:0]    ratio_squared,
	input logic [rsq_pkg::STAT_W-1:0]   status
);
	import rsq_pkg::*;

	// error results carry zero payload
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> mass_r == '0 && ratio_squared == '0)
		else $error("non-zero payload on flagged result");

	// a stalled output freezes the input side
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input accepted while output stalled");

	// empty output register never back-pressures
	a_no_spurious_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with output register empty");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mass_r)
			&& $stable(ratio_squared) && $stable(status))
		else $error("stalled result changed");

	// reset empties the pipeline
	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind razor_mr_rsq_calc rsq_checker u_rsq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (evt.valid),
	.in_ready      (evt.ready),
	.out_valid     (res.valid),
	.out_ready     (res.ready),
	.mass_r        (res.mass_r),
	.ratio_squared (res.ratio_squared),
	.status        (res.status)
);

>>> test/razor_mr_rsq_calc_test.sv
// ----------------------------------------------------------------------------
// razor_mr_rsq_calc_test
// Self-checking bench for the razor MR / R squared pipeline. A directed
// table and then random events are driven through the event channel under
// several idling phases. An in-bench model predicts each result, and the
// result channel is compared against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module razor_mr_rsq_calc_test;
	import rsq_pkg::*;

	typedef struct packed {
		logic signed [MW-1:0] apx, apy, apz, bpx, bpy, bpz;
		logic [MET_W-1:0]     met;
		logic [AW-1:0]        ang;
	} event_t;

	typedef struct packed {
		logic [OUT_W-1:0] mr;
		logic [OUT_W-1:0] rsq;
		status_t          st;
	} razor_t;

	typedef struct packed {
		event_t ev;
		logic   known;
		razor_t res;
	} row_t;

	localparam int WATCHDOG = 20000;
	localparam int DRAIN    = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_W-1:0] cfg_wr_data = '0;

	rsq_in_if  evt ();
	rsq_out_if res ();

	razor_mr_rsq_calc uut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.evt(evt), .res(res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [CFG_W-1:0] lead_pt_min = MIN_LEAD_PT_RST;
	razor_t razor_q[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_idle = 0;
	int recv_stall = 0;
	bit done = 0;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint unsigned isqrt(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [CORDIC_W-1:0] atan_step(input int i);
		logic signed [CORDIC_W-1:0] t[24];
		t = '{34'h20000000, 34'h12E4051D, 34'h09FB385B, 34'h051111D4, 34'h028B0D43,
			34'h0145D7E1, 34'h00A2F61E, 34'h00517C55, 34'h0028BE53, 34'h00145F2E,
			34'h000A2F98, 34'h000517CC, 34'h00028BE6, 34'h000145F3, 34'h0000A2F9,
			34'h0000517C, 34'h000028BE, 34'h0000145F, 34'h00000A2F, 34'h00000517,
			34'h0000028B, 34'h00000145, 34'h000000A2, 34'h00000051};
		return t[i];
	endfunction

	function automatic razor_t razor_predict(input event_t e);
		razor_t o;
		longint signed ax, ay, az, bx, by, bz, sx, sy, zs, x, y, z, nx, c, s, mx, my, mt;
		longint unsigned at2, bt2, pa, pb, sm, dv, atbt, ad, ptsum, mtr2, q, rem, frac;
		logic [127:0] lhs, rhs;
		int i;
		ax = e.apx; ay = e.apy; az = e.apz;
		bx = e.bpx; by = e.bpy; bz = e.bpz;
		o = '{mr: '0, rsq: '0, st: ST_OK};
		at2 = ax * ax + ay * ay;
		bt2 = bx * bx + by * by;
		if (at2 <= longint'(lead_pt_min) * lead_pt_min) begin
			o.st = ST_LOW_PT;
			return o;
		end
		pa = isqrt((at2 + az * az) << 8);
		pb = isqrt((bt2 + bz * bz) << 8);
		sm = pa + pb;
		zs = (az + bz) * 16;
		dv = (longint'(sm) - zs) * (longint'(sm) + zs);
		sx = ax + bx;
		sy = ay + by;
		atbt = sx * sx + sy * sy;
		ad = bt2 >= at2 ? bt2 - at2 : at2 - bt2;
		lhs = 128'(ad) * 128'(ad << 8);
		rhs = 128'(atbt) * 128'(dv);
		if (dv == 0 || atbt == 0 || lhs >= rhs) begin
			o.st = ST_NCOMP;
			return o;
		end
		q = isqrt(dv >> 8);
		o.mr = q > OUT_MAX ? OUT_MAX : q[OUT_W-1:0];
		x = 652032874; y = 0;
		z = longint'({e.ang, 16'h0}) & 64'h3FFFFFFF;
		for (i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
			end else begin
				nx = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
			end
			x = nx;
		end
		case (e.ang[AW-1 -: 2])
			2'd0: begin c = x; s = y; end
			2'd1: begin c = -y; s = x; end
			2'd2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
		mx = (longint'(e.met) * c) >>> 22;
		my = (longint'(e.met) * s) >>> 22;
		ptsum = isqrt(at2 << 16) + isqrt(bt2 << 16);
		mt = longint'(64'(e.met) * ptsum) - (mx * sx + my * sy);
		if (mt < 0) mt = 0;
		mtr2 = longint'(mt) >> 1;
		q = mtr2 / dv;
		if (q >= 256) begin
			o.rsq = OUT_MAX;
		end else begin
			rem = mtr2 % dv;
			frac = 0;
			for (i = 0; i < 16; i++) begin
				rem <<= 1; frac <<= 1;
				if (rem >= dv) begin
					rem -= dv; frac |= 1;
				end
			end
			o.rsq = OUT_W'((q << 16) | frac);
		end
		return o;
	endfunction

	// result side: sample at rising edge, stall ready at falling edge
	always @(posedge clk) begin
		razor_t got, want;
		if (arst_n && res.valid && res.ready) begin
			got = '{mr: res.mass_r, rsq: res.ratio_squared, st: status_t'(res.status)};
			if (razor_q.size() == 0) begin
				report("unexpected transaction", got.mr, -1);
			end else begin
				want = razor_q.pop_front();
				if (got.mr !== want.mr) report("mass_r", got.mr, want.mr);
				if (got.rsq !== want.rsq) report("ratio_squared", got.rsq, want.rsq);
				if (got.st !== want.st) report("status", got.st, want.st);
			end
		end
	end

	always @(posedge clk) begin
		if ((evt.valid && evt.ready) || (res.valid && res.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG && !done) begin
			$display("watchdog expired");
			$display("razor_mr_rsq_calc_test: FAIL");
			$finish;
		end
	end

	always @(negedge clk)
		res.ready <= ($urandom_range(99) >= recv_stall);

	task automatic config_write(input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		lead_pt_min = v;
	endtask

	task automatic wait_drained();
		evt.valid <= 1'b0;
		while (razor_q.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	// evt.valid is driven at falling edges; acceptance is seen at a rising edge with evt.ready high
	task automatic send(input event_t e, input logic known, input razor_t want);
		razor_t p;
		while ($urandom_range(99) < send_idle) begin
			evt.valid <= 1'b0;
			@(negedge clk);
		end
		p = razor_predict(e);
		if (known && p !== want) report("table row", p.mr, want.mr);
		evt.valid <= 1'b1;
		{evt.hemi_a_px, evt.hemi_a_py, evt.hemi_a_pz, evt.hemi_b_px, evt.hemi_b_py,
			evt.hemi_b_pz, evt.met_magnitude, evt.met_angle} <= e;
		do @(posedge clk); while (!evt.ready);
		razor_q.push_back(p);
		@(negedge clk);
	endtask

	function automatic logic signed [MW-1:0] rand_mom(input int sh);
		logic signed [MW-1:0] v;
		v = $urandom;
		return v >>> sh;
	endfunction

	function automatic event_t rand_event();
		event_t e;
		int sh;
		sh = $urandom_range(12);
		e.apx = rand_mom(sh); e.apy = rand_mom(sh); e.apz = rand_mom($urandom_range(12));
		e.bpx = rand_mom(sh); e.bpy = rand_mom(sh); e.bpz = rand_mom($urandom_range(12));
		e.met = MET_W'($urandom) >> $urandom_range(12);
		e.ang = $urandom;
		if ($urandom_range(9) == 0) e.apz = -e.bpz;
		return e;
	endfunction

	localparam logic signed [MW-1:0] PMAX = {1'b0, {MW-1{1'b1}}};
	localparam logic signed [MW-1:0] PMIN = {1'b1, {MW-1{1'b0}}};
	localparam razor_t LOWPT = '{mr: '0, rsq: '0, st: ST_LOW_PT};
	localparam razor_t NCOMP = '{mr: '0, rsq: '0, st: ST_NCOMP};
	localparam razor_t ANY = '{mr: '0, rsq: '0, st: ST_OK};

	row_t tbl[] = '{
		'{'{0, 0, 0, 0, 0, 0, 0, 0}, 1, LOWPT},
		'{'{26, 0, 0, 500, 0, 0, 100, 0}, 1, LOWPT},
		'{'{27, 0, 0, 500, 0, 0, 100, 0}, 0, ANY},
		'{'{1000, 0, 0, -1000, 0, 0, 500, 16384}, 1, NCOMP},
		'{'{1000, 0, 0, 1000, 0, 0, 500, 0}, 0, ANY},
		'{'{PMAX, PMAX, PMAX, PMIN, PMAX, PMIN, {MET_W{1'b1}}, 16'hFFFF}, 0, ANY},
		'{'{PMIN, PMIN, PMIN, PMAX, PMIN, PMAX, {MET_W{1'b1}}, 16'h8000}, 0, ANY},
		'{'{PMAX, 0, 0, 0, PMAX, 0, {MET_W{1'b1}}, 16'h4000}, 0, ANY},
		'{'{PMIN, 0, 0, 0, PMIN, 0, 0, 16'hC000}, 0, ANY},
		'{'{5000, 300, -7000, -4000, 900, 8000, 12345, 16'h1234}, 0, ANY},
		'{'{300, 0, 0, 0, 300, 0, {MET_W{1'b1}}, 16'h6000}, 0, ANY},
		'{'{-3000, 2000, 100, 2500, -2500, -100, 4000, 16'hA5A5}, 0, ANY}
	};

	initial begin
		event_t e;
		int n, ph;
		int idle_tab[4][2];
		idle_tab = '{'{0, 0}, '{46, 0}, '{0, 46}, '{31, 31}};
		evt.valid = 1'b0;
		{evt.hemi_a_px, evt.hemi_a_py, evt.hemi_a_pz, evt.hemi_b_px, evt.hemi_b_py,
			evt.hemi_b_pz, evt.met_magnitude, evt.met_angle} = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (tbl[i]) send(tbl[i].ev, tbl[i].known, tbl[i].res);
		wait_drained();
		config_write(16'hFFFF);
		e = rand_event(); e.apx = MW'(16'hFFFF); e.apy = '0;
		send(e, 1, LOWPT);
		e.apx = 24'h10000;
		send(e, 0, ANY);
		n = 0;
		for (ph = 0; ph < 8; ph++) begin
			wait_drained();
			case (ph % 4)
				0: config_write(MIN_LEAD_PT_RST);
				1: config_write(0);
				2: config_write(CFG_W'($urandom));
				default: config_write(CFG_W'($urandom_range(2000)));
			endcase
			send_idle = idle_tab[ph % 4][0];
			recv_stall = idle_tab[ph % 4][1];
			repeat (240) begin
				send(rand_event(), 0, ANY);
				n++;
				if (n == 100) wait_drained();
			end
		end
		evt.valid <= 1'b0;
		while (razor_q.size() != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		done = 1;
		if (errors == 0)
			$display("razor_mr_rsq_calc_test: PASS");
		else
			$display("razor_mr_rsq_calc_test: FAIL");
		$finish;
	end

endmodule
